>>> sv/wsp_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes, reset values and the types that join the
// csr block, controller and datapath of the wheel drive. No dependencies.
package wsp_pkg;

   localparam int DIST_W   = 12;
   localparam int ENC_W    = 8;
   localparam int PULSE_W  = 12;
   localparam int GAIN_W   = 12;
   localparam int SPEED_W  = 10;
   localparam int TRAV_W   = 13;
   localparam int TGT_W    = 12;
   localparam int ERR_W    = 9;
   localparam int DIFF_W   = 10;
   localparam int SUM_W    = 24;
   localparam int PRODI_W  = SUM_W + GAIN_W + 1;
   localparam int PRODD_W  = DIFF_W + GAIN_W + 1;
   localparam int TOT_W    = 38;
   localparam int CTL_W    = TOT_W + GAIN_W + 1;
   localparam int DRV_W    = 54;
   localparam int FRAC_W   = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_SPEED    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CRUISE_SPEED  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NEUTRAL_PULSE = 3'd5;

   localparam logic [GAIN_W-1:0]  RST_PROP_GAIN     = 12'd640;
   localparam logic [GAIN_W-1:0]  RST_INTEGRAL_GAIN = 12'd119;
   localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN    = 12'd136;
   localparam logic [SPEED_W-1:0] RST_SLOW_SPEED    = 10'd110;
   localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED  = 10'd180;
   localparam logic [PULSE_W-1:0] RST_NEUTRAL_PULSE = 12'd1500;

   // Pulse count = dist*100/div; div is 138 cm-hundredths, or 136 for long moves.
   // Reciprocal folds in the factor 100: floor(2^24/div)*100.
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 24;
   localparam int QPROD_W     = DIST_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_NEAR = 24'd12157400;
   localparam logic [RECIP_W-1:0] RECIP_FAR  = 24'd12336100;
   localparam logic [7:0]         DIV_NEAR   = 8'd138;
   localparam logic [7:0]         DIV_FAR    = 8'd136;
   localparam logic [DIST_W-1:0]  DIST_SPLIT = 12'd200;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = -24'sh800000;

   typedef struct packed {
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  integral_gain;
      logic [GAIN_W-1:0]  deriv_gain;
      logic [SPEED_W-1:0] slow_speed;
      logic [SPEED_W-1:0] cruise_speed;
      logic [PULSE_W-1:0] neutral_pulse;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic mul;
      logic sum;
      logic ctl;
      logic load;
   } cmd_type;

endpackage

>>> sv/wsp_req_if.sv
`timescale 1ns / 1ps
// Request channel: start items and encoder samples.
// Depends on wsp_pkg for field widths.
interface wsp_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [wsp_pkg::DIST_W-1:0]  distance_cm;
   logic                        backward;
   logic [wsp_pkg::ENC_W-1:0]   encoder_one;
   logic [wsp_pkg::ENC_W-1:0]   encoder_two;

   modport source (output valid, kind, distance_cm, backward, encoder_one, encoder_two,
                   input ready);
   modport sink   (input valid, kind, distance_cm, backward, encoder_one, encoder_two,
                   output ready);
endinterface

>>> sv/wsp_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: two servo pulse widths and the done flag.
// Depends on wsp_pkg for field widths.
interface wsp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [wsp_pkg::PULSE_W-1:0] right_pulse;
   logic [wsp_pkg::PULSE_W-1:0] left_pulse;
   logic                        done_res;

   modport source (output valid, right_pulse, left_pulse, done_res, input ready);
   modport sink   (input valid, right_pulse, left_pulse, done_res, output ready);
endinterface

>>> sv/wsp_csr_if.sv
`timescale 1ns / 1ps
// Register write channel: index and data per beat.
// Depends on wsp_pkg for field widths.
interface wsp_csr_if;
   logic                           valid;
   logic                           ready;
   logic [wsp_pkg::CSR_IDX_W-1:0]  index;
   logic [wsp_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/wheel_sync_pid_drive.sv
`timescale 1ns / 1ps
// Top level of the differential-drive move controller.
// Depends on wsp_pkg, the three channel interfaces, wsp_csr, wsp_ctrl and wsp_dp.
//
// Use: send a start beat (kind 0) with distance and direction, then one
// sample beat (kind 1) per encoder period with the pulses counted on each
// wheel. Every request beat yields exactly one response beat carrying the
// right and left servo pulse widths and the done flag.
// Registers are written on the csr channel, index 0..5, one beat per cycle;
// unknown indexes are dropped. Write only while no request is in flight.
// Timing: a request beat is taken in the idle state and walks through four
// further steps (gain multiplies, term sum, proportional multiply, output
// mix); the response is shown once the output step loads it, and a new
// request is taken only after the block is back in idle. The two
// dependent multiplier stages of the PID set the length of this walk.
// The result register decouples the channels: the next request is taken
// while a response waits; if the receiver still stalls when that next
// result is ready, the block holds in its output step until the slot frees.
// Reset (synchronous) restores default gains and speeds, clears the move
// state and empties the response register.
module wheel_sync_pid_drive (
   input  logic       clock,
   input  logic       reset,
   wsp_req_if.sink    req_if,
   wsp_rsp_if.source  rsp_if,
   wsp_csr_if.sink    csr_if
);

   wsp_pkg::cfg_type cfg;
   wsp_pkg::cmd_type cmd;

   wsp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_if.valid),
      .csr_index (csr_if.index),
      .csr_data  (csr_if.data),
      .csr_ready (csr_if.ready),
      .cfg       (cfg)
   );

   wsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   wsp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .req_kind        (req_if.kind),
      .req_distance_cm (req_if.distance_cm),
      .req_backward    (req_if.backward),
      .req_encoder_one (req_if.encoder_one),
      .req_encoder_two (req_if.encoder_two),
      .rsp_right_pulse (rsp_if.right_pulse),
      .rsp_left_pulse  (rsp_if.left_pulse),
      .rsp_done_res    (rsp_if.done_res)
   );

endmodule

>>> sv/wsp_csr.sv
`timescale 1ns / 1ps
// Configuration register file: gains, speeds and neutral pulse width.
// Depends on wsp_pkg.
module wsp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [wsp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wsp_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                           csr_ready,
   output wsp_pkg::cfg_type               cfg
);

   wsp_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            wsp_pkg::REG_PROP_GAIN:     cfg_in.prop_gain     = csr_data;
            wsp_pkg::REG_INTEGRAL_GAIN: cfg_in.integral_gain = csr_data;
            wsp_pkg::REG_DERIV_GAIN:    cfg_in.deriv_gain    = csr_data;
            wsp_pkg::REG_SLOW_SPEED:    cfg_in.slow_speed    = csr_data[wsp_pkg::SPEED_W-1:0];
            wsp_pkg::REG_CRUISE_SPEED:  cfg_in.cruise_speed  = csr_data[wsp_pkg::SPEED_W-1:0];
            wsp_pkg::REG_NEUTRAL_PULSE: cfg_in.neutral_pulse = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain     <= wsp_pkg::RST_PROP_GAIN;
         cfg_ff.integral_gain <= wsp_pkg::RST_INTEGRAL_GAIN;
         cfg_ff.deriv_gain    <= wsp_pkg::RST_DERIV_GAIN;
         cfg_ff.slow_speed    <= wsp_pkg::RST_SLOW_SPEED;
         cfg_ff.cruise_speed  <= wsp_pkg::RST_CRUISE_SPEED;
         cfg_ff.neutral_pulse <= wsp_pkg::RST_NEUTRAL_PULSE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> sv/wsp_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: steps each accepted beat through the datapath stages and owns
// the response valid flag. Depends on wsp_pkg.
module wsp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wsp_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_CTL  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_CTL;
         end
         ST_CTL: begin
            cmd.ctl  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/wsp_dp.sv
`timescale 1ns / 1ps
// Datapath: move state, target division, PID terms, drive mixing and the
// response payload register. Depends on wsp_pkg.
module wsp_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  wsp_pkg::cmd_type             cmd,
   input  wsp_pkg::cfg_type             cfg,
   input  logic                         req_kind,
   input  logic [wsp_pkg::DIST_W-1:0]   req_distance_cm,
   input  logic                         req_backward,
   input  logic [wsp_pkg::ENC_W-1:0]    req_encoder_one,
   input  logic [wsp_pkg::ENC_W-1:0]    req_encoder_two,
   output logic [wsp_pkg::PULSE_W-1:0]  rsp_right_pulse,
   output logic [wsp_pkg::PULSE_W-1:0]  rsp_left_pulse,
   output logic                         rsp_done_res
);

   localparam int DW = wsp_pkg::DRV_W;
   localparam int FW = wsp_pkg::FRAC_W;
   localparam int PW = wsp_pkg::PULSE_W;

   function automatic logic [PW-1:0] sat_pulse(input logic signed [DW-1:0] v);
      logic [PW-1:0] r;
      priority if (v[DW-1])           r = '0;
      else if (|v[DW-2:FW+PW])        r = '1;
      else                            r = v[FW+PW-1:FW];
      return r;
   endfunction

   // move state
   logic                               active_ff;
   logic [wsp_pkg::TRAV_W-1:0]         travelled_ff;
   logic [wsp_pkg::TGT_W-1:0]          target_ff;
   logic                               reverse_ff;
   logic signed [wsp_pkg::ERR_W-1:0]   prev_error_ff;
   logic signed [wsp_pkg::SUM_W-1:0]   error_sum_ff;

   // per-beat working registers
   logic                               kind_ff;
   logic                               was_active_ff;
   logic                               passed_ff;
   logic                               far_ff;
   logic [wsp_pkg::DIST_W-1:0]         dist_ff;
   logic [wsp_pkg::QPROD_W-1:0]        qprod_ff;
   logic [wsp_pkg::TGT_W-1:0]          q0_ff;
   logic signed [wsp_pkg::ERR_W-1:0]   err_ff;
   logic signed [wsp_pkg::DIFF_W-1:0]  diff_ff;
   logic signed [wsp_pkg::PRODI_W-1:0] prod_i_ff;
   logic signed [wsp_pkg::PRODD_W-1:0] prod_d_ff;
   logic signed [wsp_pkg::TOT_W-1:0]   tot_ff;
   logic signed [wsp_pkg::CTL_W-1:0]   ctl_ff;
   logic                               slow_ff;

   logic [PW-1:0]                      right_ff, left_ff;
   logic                               done_ff;

   // accept-cycle logic
   logic signed [wsp_pkg::ERR_W-1:0]   err_now;
   logic [wsp_pkg::ENC_W:0]            enc_pair;
   logic [wsp_pkg::TRAV_W-1:0]         trav_now;
   logic signed [wsp_pkg::SUM_W:0]     sum_wide;
   logic signed [wsp_pkg::SUM_W-1:0]   sum_now;
   logic                               far_now;

   // target correction
   logic [19:0]                        dist_x100;
   logic [19:0]                        q_times_div;
   logic [19:0]                        rem;
   logic [7:0]                         divisor;

   // speed selection
   logic [19:0]                        trav_x100;
   logic [19:0]                        tgt_x85;
   logic [16:0]                        trav_x10;

   // drive mixing
   logic [wsp_pkg::SPEED_W-1:0]        speed;
   logic signed [DW-1:0]               base_q, neutral_q, ctl_q, fwd_r, fwd_l;
   logic signed [DW-1:0]               v_right, v_left;

   always_comb begin
      err_now  = $signed({1'b0, req_encoder_one}) - $signed({1'b0, req_encoder_two});
      enc_pair = {1'b0, req_encoder_one} + {1'b0, req_encoder_two};
      trav_now = travelled_ff + {{(wsp_pkg::TRAV_W-wsp_pkg::ENC_W){1'b0}},
                                 enc_pair[wsp_pkg::ENC_W:1]};
      sum_wide = {error_sum_ff[wsp_pkg::SUM_W-1], error_sum_ff}
               + {{(wsp_pkg::SUM_W+1-wsp_pkg::ERR_W){prev_error_ff[wsp_pkg::ERR_W-1]}},
                  prev_error_ff};
      // top two bits disagree on overflow
      if (sum_wide[wsp_pkg::SUM_W] != sum_wide[wsp_pkg::SUM_W-1]) begin
         sum_now = sum_wide[wsp_pkg::SUM_W] ? wsp_pkg::SUM_MIN : wsp_pkg::SUM_MAX;
      end else begin
         sum_now = sum_wide[wsp_pkg::SUM_W-1:0];
      end
      far_now = (req_distance_cm > wsp_pkg::DIST_SPLIT);
   end

   always_comb begin
      divisor     = far_ff ? wsp_pkg::DIV_FAR : wsp_pkg::DIV_NEAR;
      dist_x100   = {8'b0, dist_ff} * 20'd100;
      q_times_div = {8'b0, q0_ff} * {12'b0, divisor};
      rem         = dist_x100 - q_times_div;
   end

   always_comb begin
      trav_x100 = {7'b0, travelled_ff} * 20'd100;
      tgt_x85   = {8'b0, target_ff} * 20'd85;
      trav_x10  = {4'b0, travelled_ff} * 17'd10;
   end

   always_comb begin
      speed     = slow_ff ? cfg.slow_speed : cfg.cruise_speed;
      base_q    = DW'({speed, {FW{1'b0}}});
      neutral_q = DW'({cfg.neutral_pulse, {FW{1'b0}}});
      ctl_q     = DW'(ctl_ff);
      fwd_r     = base_q + ctl_q;
      fwd_l     = base_q - ctl_q;
      v_right   = reverse_ff ? (neutral_q - fwd_r) : (neutral_q + fwd_r);
      v_left    = reverse_ff ? (neutral_q - fwd_l) : (neutral_q + fwd_l);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         travelled_ff  <= '0;
         target_ff     <= '0;
         reverse_ff    <= 1'b0;
         prev_error_ff <= '0;
         error_sum_ff  <= '0;
      end else begin
         if (cmd.accept) begin
            if (!req_kind) begin
               reverse_ff    <= req_backward;
               travelled_ff  <= '0;
               prev_error_ff <= '0;
               error_sum_ff  <= '0;
               active_ff     <= 1'b1;
            end else if (active_ff) begin
               travelled_ff  <= trav_now;
               error_sum_ff  <= sum_now;
               prev_error_ff <= err_now;
               if (trav_now > {1'b0, target_ff}) active_ff <= 1'b0;
            end
         end
         // start beat: round the reciprocal estimate up when one short
         if (cmd.sum && !kind_ff) begin
            target_ff <= (rem >= {12'b0, divisor}) ? q0_ff + 1'b1 : q0_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff       <= req_kind;
         was_active_ff <= active_ff;
         passed_ff     <= (trav_now > {1'b0, target_ff});
         far_ff        <= far_now;
         dist_ff       <= req_distance_cm;
         qprod_ff      <= {{wsp_pkg::RECIP_W{1'b0}}, req_distance_cm}
                        * {{wsp_pkg::DIST_W{1'b0}},
                           (far_now ? wsp_pkg::RECIP_FAR : wsp_pkg::RECIP_NEAR)};
         err_ff        <= err_now;
         diff_ff       <= wsp_pkg::DIFF_W'(err_now) - wsp_pkg::DIFF_W'(prev_error_ff);
      end
      if (cmd.mul) begin
         prod_i_ff <= error_sum_ff * $signed({1'b0, cfg.integral_gain});
         prod_d_ff <= diff_ff * $signed({1'b0, cfg.deriv_gain});
         q0_ff     <= qprod_ff[wsp_pkg::QPROD_W-1:wsp_pkg::RECIP_SHIFT];
      end
      if (cmd.sum) begin
         tot_ff <= (wsp_pkg::TOT_W'(err_ff) <<< 8) + wsp_pkg::TOT_W'(prod_i_ff)
                 + wsp_pkg::TOT_W'(prod_d_ff);
      end
      if (cmd.ctl) begin
         ctl_ff  <= tot_ff * $signed({1'b0, cfg.prop_gain});
         slow_ff <= (trav_x100 >= tgt_x85) || (trav_x10 <= {5'b0, target_ff});
      end
      if (cmd.load) begin
         priority if (!kind_ff) begin
            right_ff <= cfg.neutral_pulse;
            left_ff  <= cfg.neutral_pulse;
            done_ff  <= 1'b0;
         end else if (!was_active_ff || passed_ff) begin
            right_ff <= cfg.neutral_pulse;
            left_ff  <= cfg.neutral_pulse;
            done_ff  <= 1'b1;
         end else begin
            right_ff <= sat_pulse(v_right);
            left_ff  <= sat_pulse(v_left);
            done_ff  <= 1'b0;
         end
      end
   end

   assign rsp_right_pulse = right_ff;
   assign rsp_left_pulse  = left_ff;
   assign rsp_done_res    = done_ff;

endmodule

>>> sv/wsp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for wheel_sync_pid_drive, attached by bind.
// Depends on wsp_pkg for widths.
module wsp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [wsp_pkg::PULSE_W-1:0] right_pulse,
   input logic [wsp_pkg::PULSE_W-1:0] left_pulse,
   input logic                        done_res
);

   // a held response beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(right_pulse)
                                && $stable(left_pulse) && $stable(done_res))
      else $error("response payload changed while stalled");

   // reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one beat in flight: no request taken in the cycle after one was accepted
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");

   // done beats always drive both wheels to the same (neutral) width
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> right_pulse == left_pulse)
      else $error("done beat with unequal pulses");

endmodule

bind wheel_sync_pid_drive wsp_checker u_wsp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .right_pulse (rsp_if.right_pulse),
   .left_pulse  (rsp_if.left_pulse),
   .done_res    (rsp_if.done_res)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for wheel_sync_pid_drive: directed and random move
// sequences, register sweeps and back-pressure, checked beat by beat.
// Depends on wsp_pkg, the req/rsp/csr channel interfaces and wheel_sync_pid_drive.
module testbench;
   import wsp_pkg::*;

   localparam int      CLK_PERIOD   = 20;
   localparam longint  RUN_LIMIT_NS = 5_000_000;
   localparam logic    KIND_START   = 1'b0;
   localparam logic    KIND_SAMPLE  = 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int      LONG_MOVE_CM = 200;
   localparam int      CM_X100_NEAR = 138;
   localparam int      CM_X100_FAR  = 136;
   localparam longint  INTEG_MAX    = 8388607;
   localparam longint  INTEG_MIN    = -8388608;
   localparam longint  PULSE_MAX    = 4095;
   localparam longint  Q16_ONE      = 65536;

   localparam cfg_type DEFAULT_SETTING = '{RST_PROP_GAIN, RST_INTEGRAL_GAIN, RST_DERIV_GAIN,
                                           RST_SLOW_SPEED, RST_CRUISE_SPEED,
                                           RST_NEUTRAL_PULSE};

   typedef struct {
      logic              kind;
      logic [DIST_W-1:0] dist_cm;
      logic              back;
      logic [ENC_W-1:0]  enc_one;
      logic [ENC_W-1:0]  enc_two;
   } drive_cmd_type;

   typedef struct {
      logic [PULSE_W-1:0] right;
      logic [PULSE_W-1:0] left;
      logic               done;
   } servo_out_type;

   logic clock = 1'b0;
   logic reset;

   wsp_req_if req_bus();
   wsp_rsp_if rsp_bus();
   wsp_csr_if csr_bus();

   wheel_sync_pid_drive dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // predictor copy of registers and move state
   cfg_type                  drive_cfg;
   logic                     move_active;
   logic [TRAV_W-1:0]        move_travelled;
   logic [TGT_W-1:0]         move_target;
   logic                     move_reverse;
   logic signed [ERR_W-1:0]  last_err;
   logic signed [SUM_W-1:0]  err_integral;

   servo_out_type servo_expected[$];

   bit req_gaps   = 1'b1;
   bit rsp_stalls = 1'b1;
   int rsp_hold_cycles = 0;

   int mismatch_count   = 0;
   int beats_sent       = 0;
   int results_seen     = 0;
   int moves_started    = 0;
   int moves_finished   = 0;
   int settings_applied = 0;

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("ERROR %0t: response beat %0d: %s", $time, results_seen, what);
   endtask

   function automatic logic [PULSE_W-1:0] servo_pulse(longint speed, longint ctl);
      longint dir;
      longint v;
      dir = move_reverse ? -1 : 1;
      v = (longint'(drive_cfg.neutral_pulse) * Q16_ONE + dir * (speed * Q16_ONE + ctl))
          / Q16_ONE;
      if (v < 0)
         return '0;
      if (v > PULSE_MAX)
         return '1;
      return PULSE_W'(v);
   endfunction

   // Updates the move state for one accepted beat and returns its response.
   function automatic servo_out_type predict_servo(drive_cmd_type c);
      servo_out_type o;
      longint err, integ_next, tot, ctl, speed, mean;
      o.right = drive_cfg.neutral_pulse;
      o.left  = drive_cfg.neutral_pulse;
      o.done  = 1'b1;
      if (c.kind == KIND_START) begin
         move_target = TGT_W'((int'(c.dist_cm) * 100) /
                              (int'(c.dist_cm) > LONG_MOVE_CM ? CM_X100_FAR : CM_X100_NEAR));
         move_reverse   = c.back;
         move_travelled = '0;
         last_err       = '0;
         err_integral   = '0;
         move_active    = 1'b1;
         o.done         = 1'b0;
         moves_started++;
         return o;
      end
      if (!move_active)
         return o;

      mean = (longint'(c.enc_one) + longint'(c.enc_two)) / 2;
      move_travelled = move_travelled + TRAV_W'(mean);
      err = longint'(c.enc_one) - longint'(c.enc_two);
      // integral term accumulates the previous error, not the current one
      integ_next = longint'(err_integral) + longint'(last_err);
      if (integ_next > INTEG_MAX)
         integ_next = INTEG_MAX;
      if (integ_next < INTEG_MIN)
         integ_next = INTEG_MIN;
      err_integral = SUM_W'(integ_next);
      tot = err * 256
          + longint'(err_integral) * longint'(drive_cfg.integral_gain)
          + (err - longint'(last_err)) * longint'(drive_cfg.deriv_gain);
      ctl = tot * longint'(drive_cfg.prop_gain);
      last_err = ERR_W'(err);

      if (move_travelled > move_target) begin
         move_active = 1'b0;
         moves_finished++;
         return o;
      end
      if (longint'(move_travelled) * 100 >= longint'(move_target) * 85 ||
          longint'(move_travelled) * 10 <= longint'(move_target))
         speed = longint'(drive_cfg.slow_speed);
      else
         speed = longint'(drive_cfg.cruise_speed);
      o.right = servo_pulse(speed, ctl);
      o.left  = servo_pulse(speed, -ctl);
      o.done  = 1'b0;
      return o;
   endfunction

   task automatic send_cmd(drive_cmd_type c);
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= c.kind;
      req_bus.distance_cm <= c.dist_cm;
      req_bus.backward    <= c.back;
      req_bus.encoder_one <= c.enc_one;
      req_bus.encoder_two <= c.enc_two;
      do @(posedge clock); while (!req_bus.ready);
      servo_expected.push_back(predict_servo(c));
      beats_sent++;
      if (req_gaps && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic start_move(int move_cm, int back);
      drive_cmd_type c;
      c.kind    = KIND_START;
      c.dist_cm = DIST_W'(move_cm);
      c.back    = 1'(back);
      c.enc_one = ENC_W'($urandom());
      c.enc_two = ENC_W'($urandom());
      send_cmd(c);
   endtask

   task automatic feed_sample(int enc_one, int enc_two);
      drive_cmd_type c;
      c.kind    = KIND_SAMPLE;
      c.dist_cm = DIST_W'($urandom());
      c.back    = 1'($urandom());
      c.enc_one = ENC_W'(enc_one);
      c.enc_two = ENC_W'(enc_two);
      send_cmd(c);
   endtask

   // Wheels roughly matched around a base count, now and then fully random.
   task automatic feed_random_sample(int spread);
      int base, other;
      if ($urandom_range(0, 4) == 0) begin
         feed_sample($urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
         base  = $urandom_range(0, spread);
         other = base + $urandom_range(0, 16) - 8;
         if (other < 0)
            other = 0;
         if (other > 255)
            other = 255;
         feed_sample(base, other);
      end
   endtask

   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (servo_expected.size() != 0);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_PROP_GAIN:     drive_cfg.prop_gain     = value;
         REG_INTEGRAL_GAIN: drive_cfg.integral_gain = value;
         REG_DERIV_GAIN:    drive_cfg.deriv_gain    = value;
         REG_SLOW_SPEED:    drive_cfg.slow_speed    = value[SPEED_W-1:0];
         REG_CRUISE_SPEED:  drive_cfg.cruise_speed  = value[SPEED_W-1:0];
         REG_NEUTRAL_PULSE: drive_cfg.neutral_pulse = value;
         default: ;
      endcase
   endtask

   task automatic set_config(cfg_type c);
      csr_write(REG_PROP_GAIN,     c.prop_gain);
      csr_write(REG_INTEGRAL_GAIN, c.integral_gain);
      csr_write(REG_DERIV_GAIN,    c.deriv_gain);
      csr_write(REG_SLOW_SPEED,    CSR_DATA_W'(c.slow_speed));
      csr_write(REG_CRUISE_SPEED,  CSR_DATA_W'(c.cruise_speed));
      csr_write(REG_NEUTRAL_PULSE, c.neutral_pulse);
      csr_bus.valid <= 1'b0;
      settings_applied++;
   endtask

   function automatic cfg_type random_setting();
      cfg_type c;
      case ($urandom_range(0, 5))
         0: c = '0;
         1: c = '1;
         2: c = DEFAULT_SETTING;
         default: begin
            c.prop_gain     = $urandom_range(0, 1) ? GAIN_W'($urandom_range(0, 700))
                                                   : GAIN_W'($urandom());
            c.integral_gain = $urandom_range(0, 1) ? GAIN_W'($urandom_range(0, 300))
                                                   : GAIN_W'($urandom());
            c.deriv_gain    = $urandom_range(0, 1) ? GAIN_W'($urandom_range(0, 300))
                                                   : GAIN_W'($urandom());
            c.slow_speed    = SPEED_W'($urandom());
            c.cruise_speed  = SPEED_W'($urandom());
            c.neutral_pulse = PULSE_W'($urandom());
         end
      endcase
      return c;
   endfunction

   // One start beat then samples until the target is passed or the cap is hit,
   // with the odd restart thrown in and sometimes a trailing sample after the move.
   task automatic run_random_move();
      int move_cm, cap, spread, n;
      case ($urandom_range(0, 9))
         7, 8: move_cm = $urandom_range(0, 4095);
         9: begin
            case ($urandom_range(0, 3))
               0: move_cm = 0;
               1: move_cm = LONG_MOVE_CM;
               2: move_cm = LONG_MOVE_CM + 1;
               default: move_cm = 4095;
            endcase
         end
         default: move_cm = $urandom_range(0, 300);
      endcase
      start_move(move_cm, $urandom_range(0, 1));
      cap    = $urandom_range(4, 80);
      spread = $urandom_range(1, 255);
      n      = 0;
      while (move_active && n < cap) begin
         if ($urandom_range(0, 19) == 0)
            start_move($urandom_range(0, 4095), $urandom_range(0, 1));
         else
            feed_random_sample(spread);
         n++;
      end
      if ($urandom_range(0, 2) == 0)
         feed_random_sample(spread);
   endtask

   task automatic test_directed();
      feed_sample(255, 0);            // sample with no move running
      start_move(0, 0);               // zero target
      feed_sample(1, 0);              // zero mean keeps the move alive
      feed_sample(0, 1);
      feed_sample(2, 2);              // any movement ends it
      feed_sample(0, 0);
      start_move(LONG_MOVE_CM, 1);
      feed_sample(255, 0);
      feed_sample(0, 255);
      feed_sample(255, 255);
      start_move(LONG_MOVE_CM + 1, 0);
      feed_sample(20, 10);            // cruise band
      feed_sample(30, 30);
      feed_sample(40, 50);
      start_move(4095, 1);            // restart mid-move
      feed_sample(255, 0);
      feed_sample(0, 255);
      wait_results_drained();
      csr_write(REG_UNUSED, '1);
      set_config('1);                 // pulses pinned at both rails
      start_move(4095, 0);
      feed_sample(255, 0);
      feed_sample(0, 255);
      wait_results_drained();
      set_config('0);
      start_move(100, 1);
      feed_sample(7, 3);
      feed_sample(200, 200);
   endtask

   // Receiver held off long enough that the result slot and the input stall.
   task automatic test_backpressure();
      wait_results_drained();
      set_config(DEFAULT_SETTING);
      rsp_hold_cycles = 80;
      start_move(4095, 0);
      repeat (12) feed_sample($urandom_range(0, 20), $urandom_range(0, 20));
   endtask

   task automatic test_drain_pause();
      start_move($urandom_range(300, 600), $urandom_range(0, 1));
      repeat (5) feed_random_sample(30);
      wait_results_drained();
      repeat (5) feed_random_sample(30);
   endtask

   task automatic test_random_moves(int count);
      int goal, next_setting;
      goal = beats_sent + count;
      next_setting = beats_sent;
      while (beats_sent < goal) begin
         if (beats_sent >= next_setting) begin
            wait_results_drained();
            set_config(random_setting());
            req_gaps     = $urandom_range(0, 3) != 0;
            rsp_stalls   = $urandom_range(0, 3) != 0;
            next_setting = beats_sent + 100;
         end
         run_random_move();
      end
   endtask

   task automatic test_no_idle_tail();
      int goal;
      wait_results_drained();
      set_config(DEFAULT_SETTING);
      req_gaps   = 1'b0;
      rsp_stalls = 1'b0;
      goal = beats_sent + 60;
      while (beats_sent < goal)
         run_random_move();
   endtask

   // receiver side: random stall bursts and the counted long hold
   initial begin : rsp_ready_drive
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_stalls && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      servo_out_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (servo_expected.size() == 0) begin
            report_mismatch("response beat with nothing outstanding");
         end else begin
            want = servo_expected.pop_front();
            if (rsp_bus.right_pulse !== want.right)
               report_mismatch($sformatf("right_pulse %0d, predicted %0d",
                                         rsp_bus.right_pulse, want.right));
            if (rsp_bus.left_pulse !== want.left)
               report_mismatch($sformatf("left_pulse %0d, predicted %0d",
                                         rsp_bus.left_pulse, want.left));
            if (rsp_bus.done_res !== want.done)
               report_mismatch($sformatf("done_res %0b, predicted %0b",
                                         rsp_bus.done_res, want.done));
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= KIND_START;
      req_bus.distance_cm <= '0;
      req_bus.backward    <= 1'b0;
      req_bus.encoder_one <= '0;
      req_bus.encoder_two <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= REG_PROP_GAIN;
      csr_bus.data        <= '0;
      drive_cfg      = DEFAULT_SETTING;
      move_active    = 1'b0;
      move_travelled = '0;
      move_target    = '0;
      move_reverse   = 1'b0;
      last_err       = '0;
      err_integral   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_backpressure();
      test_drain_pause();
      test_random_moves(700);
      test_no_idle_tail();

      req_bus.valid <= 1'b0;
      while (servo_expected.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (servo_expected.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", servo_expected.size()));

      $display("Run covered %0d request beats, %0d moves started, %0d ran past target,",
               beats_sent, moves_started, moves_finished);
      $display("across %0d register settings; %0d response beats checked.",
               settings_applied, results_seen);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
